@@ design/assert_macros.svh @@
// assertion macros shared by the mapper rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define CBSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define CBSM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/cbsm_pkg.sv @@
// constants, codes, tables and types of the cartridge mapper
package cbsm_pkg;

	localparam int ROML_BANKS = 64;
	localparam int ROMH_BANKS = 16;
	localparam int BANK_BYTES = 8192;

	localparam int FUNC_W     = 4;
	localparam int ADDR_W     = 16;
	localparam int DATA_W     = 8;
	localparam int BANK_W     = 6;
	localparam int CT_W       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam int OFS_W     = $clog2(BANK_BYTES);
	localparam int RL_BW     = (ROML_BANKS > 1) ? $clog2(ROML_BANKS) : 1;
	localparam int RH_BW     = (ROMH_BANKS > 1) ? $clog2(ROMH_BANKS) : 1;
	localparam int RL_DEPTH  = ROML_BANKS * BANK_BYTES;
	localparam int RH_DEPTH  = ROMH_BANKS * BANK_BYTES;
	localparam int RL_AW     = $clog2(RL_DEPTH);
	localparam int RH_AW     = $clog2(RH_DEPTH);
	localparam int BANK_CODES = 2 ** BANK_W;
	localparam int OCEAN_SPLIT = 16;

	localparam logic [ADDR_W-1:0] IO1_BASE = 16'hde00;

	// bus access codes
	localparam logic [FUNC_W-1:0] FN_RESET   = 4'd0;
	localparam logic [FUNC_W-1:0] FN_LOAD_L  = 4'd1;
	localparam logic [FUNC_W-1:0] FN_LOAD_H  = 4'd2;
	localparam logic [FUNC_W-1:0] FN_IO1_WR  = 4'd3;
	localparam logic [FUNC_W-1:0] FN_IO1_RD  = 4'd4;
	localparam logic [FUNC_W-1:0] FN_IO2_WR  = 4'd5;
	localparam logic [FUNC_W-1:0] FN_IO2_RD  = 4'd6;
	localparam logic [FUNC_W-1:0] FN_ROML_RD = 4'd7;
	localparam logic [FUNC_W-1:0] FN_ROMH_RD = 4'd8;

	// cartridge schemes
	localparam logic [CT_W-1:0] CT_NONE   = 3'd0;
	localparam logic [CT_W-1:0] CT_NORMAL = 3'd1;
	localparam logic [CT_W-1:0] CT_OCEAN  = 3'd2;
	localparam logic [CT_W-1:0] CT_GS     = 3'd3;
	localparam logic [CT_W-1:0] CT_MAGIC  = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CART_TYPE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROML_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HAS_ROML   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HAS_ROMH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAME_RST   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_EXROM_RST  = 3'd5;

	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef logic [FIFO_CW-1:0] fifo_cnt_t;
	typedef logic [BANK_CODES-1:0][RL_BW-1:0] rl_tab_t;
	typedef logic [BANK_CODES-1:0][RH_BW-1:0] rh_tab_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              driven;
		logic              game_line;
		logic              exrom_line;
	} out_word_t;

	function automatic rl_tab_t mk_rl_mod();
		rl_tab_t t;
		for (int i = 0; i < BANK_CODES; i++) t[i] = RL_BW'(i % ROML_BANKS);
		return t;
	endfunction

	function automatic rh_tab_t mk_rh_mod();
		rh_tab_t t;
		for (int i = 0; i < BANK_CODES; i++) t[i] = RH_BW'(i % ROMH_BANKS);
		return t;
	endfunction

	// ocean banks past the roml split land at bank minus split, wrapped
	function automatic rh_tab_t mk_ocean_rh();
		rh_tab_t t;
		for (int i = 0; i < BANK_CODES; i++)
			t[i] = RH_BW'((i + OCEAN_SPLIT * ROMH_BANKS - OCEAN_SPLIT) % ROMH_BANKS);
		return t;
	endfunction

	localparam rl_tab_t RL_MOD   = mk_rl_mod();
	localparam rh_tab_t RH_MOD   = mk_rh_mod();
	localparam rh_tab_t OCEAN_RH = mk_ocean_rh();

endpackage

@@ design/cbsm_if.sv @@
// access and result channel interfaces of the cartridge mapper
interface cbsm_access_if;
	import cbsm_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] data;
	logic [BANK_W-1:0] load_bank;

	modport source (output valid, func, address, data, load_bank, input ready);
	modport sink (input valid, func, address, data, load_bank, output ready);
endinterface

interface cbsm_result_if;
	import cbsm_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              driven;
	logic              game_line;
	logic              exrom_line;

	modport source (output valid, read_data, driven, game_line, exrom_line, input ready);
	modport sink (input valid, read_data, driven, game_line, exrom_line, output ready);
endinterface

@@ design/cbsm_ram.sv @@
// generic single-port ram with registered read
module cbsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule

@@ design/cbsm_out_fifo.sv @@
// three-word result queue that decouples the ram stage from the consumer
module cbsm_out_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cbsm_pkg::out_word_t  push_word,
	output cbsm_pkg::fifo_cnt_t  count,
	cbsm_result_if.source        result
);
	import cbsm_pkg::*;

	out_word_t            fifo_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0]   wr_ptr_q;
	logic [FIFO_PW-1:0]   rd_ptr_q;
	fifo_cnt_t            count_q;
	logic                 pop;
	out_word_t            head;

	function automatic logic [FIFO_PW-1:0] ptr_next(logic [FIFO_PW-1:0] p);
		return (p == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head              = fifo_q[rd_ptr_q];
	assign pop               = result.valid && result.ready;
	assign count             = count_q;
	assign result.valid      = (count_q != '0);
	assign result.read_data  = head.read_data;
	assign result.driven     = head.driven;
	assign result.game_line  = head.game_line;
	assign result.exrom_line = head.exrom_line;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

@@ design/cartridge_bank_switch_mapper_unit.sv @@
// cartridge bank switching mapper: bank state, rom stores and result queue
// an accepted word passes the ram stage registers, then enters the result queue
// throughput: one access word per cycle while ready, set by each single-port rom ram
// the bank register and lines update at the accept edge, so the next word sees them
// reset: arst_n clears bank, lines, registers, pipeline and queue at once
// the rom stores are not cleared; an entry is valid only once it has been loaded
`include "assert_macros.svh"

module cartridge_bank_switch_mapper_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cbsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbsm_pkg::CFG_DATA_W-1:0]    cfg_data,
	cbsm_access_if.sink                        access,
	cbsm_result_if.source                      result
);
	import cbsm_pkg::*;

	// registers
	logic [CT_W-1:0]       cart_type_q;
	logic [CFG_DATA_W-1:0] roml_count_q;
	logic                  has_roml_q;
	logic                  has_romh_q;
	logic                  game_rst_q;
	logic                  exrom_rst_q;

	// mapper state
	logic [BANK_W-1:0] bank_q;
	logic              game_q;
	logic              exrom_q;

	logic [CT_W-1:0]   t;
	logic              acc;
	logic [BANK_W-1:0] bank_d;
	logic              game_d;
	logic              exrom_d;
	logic              low_we, low_re, high_we, high_re;
	logic              drv, rom_rd, from_high, ocean_rd, ocean_low;
	logic [RL_BW-1:0]  low_bank;
	logic [RH_BW-1:0]  high_bank;
	logic [RL_BW+OFS_W-1:0] low_full;
	logic [RH_BW+OFS_W-1:0] high_full;
	logic [DATA_W-1:0] low_rdata;
	logic [DATA_W-1:0] high_rdata;

	// ram stage
	logic valid_s1, drv_s1, rom_rd_s1, high_s1, game_s1, exrom_s1;
	out_word_t word_s1;
	fifo_cnt_t fifo_count;

	assign acc          = access.valid && access.ready;
	// room for the word in flight plus any word now accepted
	assign access.ready = ((FIFO_CW + 1)'(fifo_count) + (FIFO_CW + 1)'(valid_s1))
		< (FIFO_CW + 1)'(FIFO_DEPTH);
	assign t            = (cart_type_q > CT_MAGIC) ? CT_NONE : cart_type_q;
	assign ocean_low    = ({1'b0, bank_q} < roml_count_q);

	always_comb begin
		bank_d    = bank_q;
		game_d    = game_q;
		exrom_d   = exrom_q;
		low_we    = 1'b0;
		low_re    = 1'b0;
		high_we   = 1'b0;
		high_re   = 1'b0;
		drv       = 1'b0;
		rom_rd    = 1'b0;
		from_high = 1'b0;
		ocean_rd  = 1'b0;
		low_bank  = RL_MOD[bank_q];
		high_bank = RH_MOD[bank_q];
		case (access.func)
			FN_RESET: begin
				if (t != CT_NONE) begin
					if (t inside {CT_OCEAN, CT_GS, CT_MAGIC}) bank_d = '0;
					game_d  = game_rst_q;
					exrom_d = exrom_rst_q;
				end
			end
			FN_LOAD_L: begin
				low_we   = 1'b1;
				low_bank = RL_MOD[access.load_bank];
			end
			FN_LOAD_H: begin
				high_we   = 1'b1;
				high_bank = RH_MOD[access.load_bank];
			end
			FN_IO1_WR: begin
				case (t)
					CT_OCEAN: begin
						if (access.address == IO1_BASE) bank_d = access.data[BANK_W-1:0];
					end
					CT_GS: bank_d = access.address[BANK_W-1:0];
					CT_MAGIC: begin
						if (access.address == IO1_BASE) begin
							bank_d  = {1'b0, access.data[BANK_W-2:0]};
							game_d  = 1'b1;
							exrom_d = access.data[DATA_W-1];
						end
					end
					default: ;
				endcase
			end
			FN_IO1_RD: begin
				if (t == CT_GS) begin
					bank_d = '0;
					drv    = 1'b1;
				end
			end
			FN_ROML_RD: begin
				if (has_roml_q) begin
					if (t inside {CT_NORMAL, CT_GS, CT_MAGIC}) begin
						low_re = 1'b1;
						drv    = 1'b1;
						rom_rd = 1'b1;
					end else if (t == CT_OCEAN) begin
						ocean_rd = 1'b1;
					end
				end
			end
			FN_ROMH_RD: begin
				if (t == CT_NORMAL && has_romh_q) begin
					high_re   = 1'b1;
					from_high = 1'b1;
					drv       = 1'b1;
					rom_rd    = 1'b1;
				end else if (t == CT_OCEAN && has_roml_q) begin
					ocean_rd = 1'b1;
				end
			end
			default: ;
		endcase
		// ocean split: banks below the roml count read roml, the rest romh
		if (ocean_rd) begin
			drv    = 1'b1;
			rom_rd = 1'b1;
			if (ocean_low) begin
				low_re = 1'b1;
			end else begin
				high_re   = 1'b1;
				from_high = 1'b1;
				high_bank = OCEAN_RH[bank_q];
			end
		end
	end

	assign low_full  = {low_bank, access.address[OFS_W-1:0]};
	assign high_full = {high_bank, access.address[OFS_W-1:0]};

	cbsm_ram #(.WIDTH(DATA_W), .DEPTH(RL_DEPTH)) u_roml (
		.clk   (clk),
		.en    (acc && (low_we || low_re)),
		.we    (low_we),
		.addr  (low_full[RL_AW-1:0]),
		.wdata (access.data),
		.rdata (low_rdata)
	);

	cbsm_ram #(.WIDTH(DATA_W), .DEPTH(RH_DEPTH)) u_romh (
		.clk   (clk),
		.en    (acc && (high_we || high_re)),
		.we    (high_we),
		.addr  (high_full[RH_AW-1:0]),
		.wdata (access.data),
		.rdata (high_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_type_q  <= CT_NONE;
			roml_count_q <= '0;
			has_roml_q   <= 1'b0;
			has_romh_q   <= 1'b0;
			game_rst_q   <= 1'b0;
			exrom_rst_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CART_TYPE:  cart_type_q  <= cfg_data[CT_W-1:0];
				CFG_ROML_COUNT: roml_count_q <= cfg_data;
				CFG_HAS_ROML:   has_roml_q   <= cfg_data[0];
				CFG_HAS_ROMH:   has_romh_q   <= cfg_data[0];
				CFG_GAME_RST:   game_rst_q   <= cfg_data[0];
				CFG_EXROM_RST:  exrom_rst_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= '0;
			game_q   <= 1'b0;
			exrom_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				bank_q  <= bank_d;
				game_q  <= game_d;
				exrom_q <= exrom_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			drv_s1    <= drv;
			rom_rd_s1 <= rom_rd;
			high_s1   <= from_high;
			game_s1   <= game_d;
			exrom_s1  <= exrom_d;
		end
	end

	always_comb begin
		word_s1.read_data  = rom_rd_s1 ? (high_s1 ? high_rdata : low_rdata) : '0;
		word_s1.driven     = drv_s1;
		word_s1.game_line  = game_s1;
		word_s1.exrom_line = exrom_s1;
	end

	cbsm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_word (word_s1),
		.count     (fifo_count),
		.result    (result)
	);

	`CBSM_ASSERT(a_fifo_room, valid_s1 |-> (fifo_count < FIFO_CW'(FIFO_DEPTH) || result.ready), "result queue overflow")
	`CBSM_ASSERT(a_accept_stage, acc |=> valid_s1, "accepted word missing from ram stage")
	`CBSM_ASSERT(a_undriven_zero, (result.valid && !result.driven) |-> (result.read_data == '0), "undriven word carries data")
endmodule
